FILE: src/radix_prefixed_literal_parser_top_macros.svh
// Assertion macros shared by the literal parser modules.
`ifndef RADIX_PREFIXED_LITERAL_PARSER_TOP_MACROS_SVH
`define RADIX_PREFIXED_LITERAL_PARSER_TOP_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, checked on every rising edge outside reset.
`define RPLP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked on every rising edge outside reset.
`define RPLP_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RPLP_ASSERT_IMP(label, ante, cons, msg)
`define RPLP_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

FILE: src/rplp_pkg.sv
// Shared types, constants and digit helpers for the literal parser.
package rplp_pkg;

    // Radix selected by the prefix.
    typedef enum logic [1:0] {
        RADIX_BIN = 2'd0,
        RADIX_OCT = 2'd1,
        RADIX_DEC = 2'd2,
        RADIX_HEX = 2'd3
    } radix_t;

    localparam int CHAR_W  = 8;
    localparam int VALUE_W = 16;
    localparam int DIGIT_W = 4;
    // Widest constant folded by the front part: three decimal digits, at most 999.
    localparam int VAL_W   = 10;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_ONE   = 8'h31;
    localparam logic [CHAR_W-1:0] CH_SEVEN = 8'h37;
    localparam logic [CHAR_W-1:0] CH_A     = 8'h61;
    localparam logic [CHAR_W-1:0] CH_F     = 8'h66;
    localparam logic [CHAR_W-1:0] CH_B     = 8'h62;
    localparam logic [CHAR_W-1:0] CH_O     = 8'h6f;
    localparam logic [CHAR_W-1:0] CH_D     = 8'h64;
    localparam logic [CHAR_W-1:0] CH_X     = 8'h78;
    // Offset that maps 'a' onto ten.
    localparam logic [CHAR_W-1:0] HEX_OFS  = 8'h57;

    // One queued operation for the back part.
    typedef struct packed {
        logic               start;  // load val instead of multiply-add
        radix_t             radix;
        logic [VAL_W-1:0]   val;
        logic               bad;    // an invalid digit is in this step
        logic               last;   // closes the literal, gives a result
    } op_t;

    // Numeric worth of a digit character; zero for anything else.
    function automatic logic [DIGIT_W-1:0] digit_val(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] t;
        t = '0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            t = c - CH_ZERO;
        end else if (c >= CH_A && c <= CH_F) begin
            t = c - HEX_OFS;
        end
        return t[DIGIT_W-1:0];
    endfunction

    // True when the character is a digit of the given radix.
    function automatic logic digit_ok(input radix_t r, input logic [CHAR_W-1:0] c);
        logic ok;
        ok = 1'b0;
        unique case (r)
            RADIX_BIN: ok = (c == CH_ZERO) || (c == CH_ONE);
            RADIX_OCT: ok = (c >= CH_ZERO) && (c <= CH_SEVEN);
            RADIX_DEC: ok = (c >= CH_ZERO) && (c <= CH_NINE);
            RADIX_HEX: ok = ((c >= CH_ZERO) && (c <= CH_NINE)) ||
                            ((c >= CH_A) && (c <= CH_F));
            default:   ok = 1'b0;
        endcase
        return ok;
    endfunction

endpackage

FILE: src/radix_prefixed_literal_parser_top.sv
// Top level of the radix-prefixed literal parser.
//
//  Channel  Direction  Payload                               Transfer rule
//  s_*      in         tdata[7:0] char_code, tlast is_last   s_tvalid && s_tready
//  m_*      out        tdata[15:0] value, tuser ok           m_tvalid && m_tready
//
// One character per cycle is taken while the queue is not full; a result for
// a closing character passes the queue register, then the result register.
// The four-entry step queue sets how long the input side can run on while the
// output side stalls; s_tready drops only when that queue is full.
// Reset is synchronous on aresetn low and empties queue and result register.
module radix_prefixed_literal_parser_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic        s_tlast,   // is_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] value
    output logic        m_tuser    // [0] ok
);
    import rplp_pkg::*;

    logic s_fire;
    logic push, pop, full, head_valid;
    op_t  push_op, head_op;

    assign s_tready = !full;
    assign s_fire   = s_tvalid && s_tready;

    rplp_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_fire    (s_fire),
        .char_code (s_tdata),
        .is_last   (s_tlast),
        .push      (push),
        .push_op   (push_op)
    );

    rplp_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_op    (push_op),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_op    (head_op)
    );

    rplp_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_op    (head_op),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .value      (m_tdata),
        .ok         (m_tuser)
    );

endmodule

FILE: src/rplp_front.sv
// Front part: takes characters, finds the prefix and queues accumulate steps.
`include "radix_prefixed_literal_parser_top_macros.svh"
module rplp_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_fire,
    input  logic [rplp_pkg::CHAR_W-1:0] char_code,
    input  logic                        is_last,
    output logic                        push,
    output rplp_pkg::op_t               push_op
);
    import rplp_pkg::*;

    localparam logic [1:0] POS_FIRST  = 2'd0;
    localparam logic [1:0] POS_SECOND = 2'd1;
    localparam logic [1:0] POS_THIRD  = 2'd2;
    localparam logic [1:0] POS_BODY   = 2'd3;

    logic [CHAR_W-1:0] first_reg, first_next;
    logic [CHAR_W-1:0] second_reg, second_next;
    logic [1:0]        count_reg, count_next;
    radix_t            radix_reg, radix_next;

    logic [DIGIT_W-1:0] dv_c, dv_f, dv_s;
    radix_t             pre_radix;
    logic               pre_hit;
    op_t                op;

    // Prefix recognition on the held first two characters.
    always_comb begin
        pre_hit   = 1'b0;
        pre_radix = RADIX_DEC;
        if (first_reg == CH_ZERO) begin
            pre_hit = 1'b1;
            priority if (second_reg == CH_B) begin
                pre_radix = RADIX_BIN;
            end else if (second_reg == CH_O) begin
                pre_radix = RADIX_OCT;
            end else if (second_reg == CH_D) begin
                pre_radix = RADIX_DEC;
            end else if (second_reg == CH_X) begin
                pre_radix = RADIX_HEX;
            end else begin
                pre_hit = 1'b0;
            end
        end
    end

    // Build the queued step for the current character.
    always_comb begin
        dv_c     = digit_val(char_code);
        dv_f     = digit_val(first_reg);
        dv_s     = digit_val(second_reg);
        op       = '0;
        op.radix = RADIX_DEC;
        op.last  = is_last;
        push     = 1'b0;
        unique case (count_reg)
            POS_FIRST: begin
                push     = s_fire && is_last;
                op.start = 1'b1;
                op.val   = VAL_W'(dv_c);
                op.bad   = !digit_ok(RADIX_DEC, char_code);
            end
            POS_SECOND: begin
                push     = s_fire && is_last;
                op.start = 1'b1;
                op.val   = VAL_W'(dv_f) * VAL_W'(10) + VAL_W'(dv_c);
                op.bad   = !digit_ok(RADIX_DEC, first_reg) ||
                           !digit_ok(RADIX_DEC, char_code);
            end
            POS_THIRD: begin
                push     = s_fire;
                op.start = 1'b1;
                op.radix = pre_radix;
                if (pre_hit) begin
                    op.val = VAL_W'(dv_c);
                    op.bad = !digit_ok(pre_radix, char_code);
                end else begin
                    op.val = VAL_W'(dv_f) * VAL_W'(100) + VAL_W'(dv_s) * VAL_W'(10) +
                             VAL_W'(dv_c);
                    op.bad = !digit_ok(RADIX_DEC, first_reg) ||
                             !digit_ok(RADIX_DEC, second_reg) ||
                             !digit_ok(RADIX_DEC, char_code);
                end
            end
            POS_BODY: begin
                push     = s_fire;
                op.start = 1'b0;
                op.radix = radix_reg;
                op.val   = VAL_W'(dv_c);
                op.bad   = !digit_ok(radix_reg, char_code);
            end
            default: push = 1'b0;
        endcase
        push_op = op;
    end

    // Position and prefix state for the next character.
    always_comb begin
        first_next  = first_reg;
        second_next = second_reg;
        count_next  = count_reg;
        radix_next  = radix_reg;
        if (s_fire) begin
            if (count_reg == POS_FIRST) begin
                first_next = char_code;
            end
            if (count_reg == POS_SECOND) begin
                second_next = char_code;
            end
            if (count_reg == POS_THIRD) begin
                radix_next = pre_radix;
            end
            if (count_reg != POS_BODY) begin
                count_next = count_reg + 2'd1;
            end
            if (is_last) begin
                first_next  = '0;
                second_next = '0;
                count_next  = POS_FIRST;
                radix_next  = RADIX_DEC;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_reg  <= '0;
            second_reg <= '0;
            count_reg  <= POS_FIRST;
            radix_reg  <= RADIX_DEC;
        end else begin
            first_reg  <= first_next;
            second_reg <= second_next;
            count_reg  <= count_next;
            radix_reg  <= radix_next;
        end
    end

    // A closing character always leaves the front ready for a new literal.
    `RPLP_ASSERT_NXT(a_front_restart, s_fire && is_last, count_reg == POS_FIRST, "front did not restart after the last character")
    // Characters past the prefix always queue a step.
    `RPLP_ASSERT_IMP(a_front_body_push, s_fire && count_reg == POS_BODY, push && !push_op.start, "body character queued no step")

endmodule

FILE: src/rplp_queue.sv
// Short queue of accumulate steps between the front and back parts.
`include "radix_prefixed_literal_parser_top_macros.svh"
module rplp_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  rplp_pkg::op_t push_op,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output rplp_pkg::op_t head_op
);
    import rplp_pkg::*;

    op_t               slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_op    = slot_reg[rd_ptr_reg];

    // Occupancy follows the push and pop transfers.
    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    `RPLP_ASSERT_IMP(a_queue_no_overflow, push, !full, "push into a full queue")
    `RPLP_ASSERT_IMP(a_queue_no_underflow, pop, head_valid, "pop from an empty queue")

endmodule

FILE: src/rplp_back.sv
// Back part: runs the multiply-add steps and holds the result register.
`include "radix_prefixed_literal_parser_top_macros.svh"
module rplp_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         head_valid,
    input  rplp_pkg::op_t                head_op,
    output logic                         pop,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [rplp_pkg::VALUE_W-1:0] value,
    output logic                         ok
);
    import rplp_pkg::*;

    logic [VALUE_W-1:0] acc_reg, acc_next;
    logic               failed_reg, failed_next;
    logic               valid_reg, valid_next;
    logic [VALUE_W-1:0] value_reg, value_next;
    logic               ok_reg, ok_next;

    logic               slot_free;
    logic [VALUE_W-1:0] scaled;

    // A closing step waits for the result register; others go straight through.
    assign slot_free = !valid_reg || m_tready;
    assign pop       = head_valid && (!head_op.last || slot_free);

    // Multiply the running value by the radix with shifts.
    always_comb begin
        unique case (head_op.radix)
            RADIX_BIN: scaled = acc_reg << 1;
            RADIX_OCT: scaled = acc_reg << 3;
            RADIX_DEC: scaled = (acc_reg << 3) + (acc_reg << 1);
            RADIX_HEX: scaled = acc_reg << 4;
            default:   scaled = acc_reg;
        endcase
    end

    // Step the accumulator and load the result on the closing step.
    always_comb begin
        acc_next    = acc_reg;
        failed_next = failed_reg;
        valid_next  = valid_reg;
        value_next  = value_reg;
        ok_next     = ok_reg;
        if (valid_reg && m_tready) begin
            valid_next = 1'b0;
        end
        if (pop) begin
            if (head_op.start) begin
                acc_next    = VALUE_W'(head_op.val);
                failed_next = head_op.bad;
            end else begin
                acc_next    = scaled + VALUE_W'(head_op.val[DIGIT_W-1:0]);
                failed_next = failed_reg || head_op.bad;
            end
            if (head_op.last) begin
                valid_next  = 1'b1;
                value_next  = failed_next ? '0 : acc_next;
                ok_next     = !failed_next;
                acc_next    = '0;
                failed_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg    <= '0;
            failed_reg <= 1'b0;
            valid_reg  <= 1'b0;
        end else begin
            acc_reg    <= acc_next;
            failed_reg <= failed_next;
            valid_reg  <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
        ok_reg    <= ok_next;
    end

    assign m_tvalid = valid_reg;
    assign value    = value_reg;
    assign ok       = ok_reg;

    `RPLP_ASSERT_IMP(a_back_fail_zero, valid_reg && !ok_reg, value_reg == '0, "failed literal with a non-zero value")
    `RPLP_ASSERT_IMP(a_back_no_overwrite, pop && head_op.last, slot_free, "result register overwritten before its transfer")

endmodule

FILE: dv/tb.sv
// Self-checking testbench for the radix-prefixed literal parser.
`timescale 1ns / 1ps

module tb;
    import rplp_pkg::*;

    // One character of a literal as it travels on the input channel.
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } char_item_t;

    // One parsed literal as it leaves on the result channel.
    typedef struct packed {
        logic [15:0] value;
        logic        ok;
    } lit_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;   // [7:0] char_code
    logic        s_tlast = 1'b0; // is_last
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;        // [15:0] value
    logic        m_tuser;        // [0] ok

    char_item_t  chars_to_send[$];
    lit_result_t results_due[$];
    char_item_t  next_char;

    // Handshake bookkeeping shared between the clocked processes.
    logic char_taken = 1'b0;
    logic char_busy = 1'b0;
    logic result_taken = 1'b0;
    logic hold_off = 1'b0;
    logic quiet;
    int   send_gap = 0;
    int   recv_gap = 0;
    int   n_accepted = 0;
    int   errors = 0;

    // Predictor state for the literal being parsed.
    logic [7:0]  lit_first = '0;
    logic [7:0]  lit_second = '0;
    int          lit_count = 0;
    radix_t      lit_radix = RADIX_DEC;
    logic [15:0] lit_acc = '0;
    logic        lit_failed = 1'b0;

    radix_prefixed_literal_parser_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 aclk = ~aclk;

    // Every fourth stretch of 64 characters runs with no idling on either side.
    assign quiet = ((n_accepted / 64) % 4) == 3;

    task automatic report(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        errors++;
    endtask

    // Fold one character into the running value, or mark the literal as failed.
    task automatic fold_digit(input logic [7:0] c);
        logic [4:0] d;
        logic [4:0] base;
        logic       hit;
        d = '0;
        hit = 1'b0;
        unique case (lit_radix)
            RADIX_BIN: base = 5'd2;
            RADIX_OCT: base = 5'd8;
            RADIX_DEC: base = 5'd10;
            default:   base = 5'd16;
        endcase
        if (c >= CH_ZERO && c <= CH_NINE) begin
            d = 5'(c - CH_ZERO);
            hit = (lit_radix == RADIX_DEC) || (lit_radix == RADIX_HEX) ||
                  (lit_radix == RADIX_OCT && d <= 7) || (lit_radix == RADIX_BIN && d <= 1);
        end else if (lit_radix == RADIX_HEX && c >= CH_A && c <= CH_F) begin
            d = 5'(c - CH_A + 8'd10);
            hit = 1'b1;
        end
        if (hit) begin
            lit_acc = lit_acc * base + d;
        end else begin
            lit_failed = 1'b1;
        end
    endtask

    // Advance the predicted parser by one accepted character.
    task automatic parse_char(input logic [7:0] c, input logic last);
        logic pre;
        pre = 1'b0;
        unique case (lit_count)
            0: begin
                lit_first = c;
                lit_count = 1;
                if (last) fold_digit(lit_first);
            end
            1: begin
                lit_second = c;
                lit_count = 2;
                if (last) begin
                    fold_digit(lit_first);
                    fold_digit(lit_second);
                end
            end
            2: begin
                // The prefix is only decided once the third character arrives.
                if (lit_first == CH_ZERO) begin
                    pre = 1'b1;
                    if (lit_second == CH_B) lit_radix = RADIX_BIN;
                    else if (lit_second == CH_O) lit_radix = RADIX_OCT;
                    else if (lit_second == CH_D) lit_radix = RADIX_DEC;
                    else if (lit_second == CH_X) lit_radix = RADIX_HEX;
                    else pre = 1'b0;
                end
                if (!pre) begin
                    lit_radix = RADIX_DEC;
                    fold_digit(lit_first);
                    fold_digit(lit_second);
                end
                fold_digit(c);
                lit_count = 3;
            end
            default: fold_digit(c);
        endcase
        if (last) begin
            results_due.push_back(lit_failed ? lit_result_t'('0) : {lit_acc, 1'b1});
            lit_first = '0;
            lit_second = '0;
            lit_count = 0;
            lit_radix = RADIX_DEC;
            lit_acc = '0;
            lit_failed = 1'b0;
        end
    endtask

    task automatic push_char(input logic [7:0] c, input logic last);
        chars_to_send.push_back('{ch: c, last: last});
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            push_char(s[i], i == s.len() - 1);
        end
    endtask

    // Sample both channels at the rising edge: predict on input transfers,
    // check on result transfers.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                parse_char(s_tdata, s_tlast);
                char_taken = 1'b1;
                n_accepted++;
            end
            if (m_tvalid && m_tready) begin
                result_taken = 1'b1;
                if (results_due.size() == 0) begin
                    report($sformatf("result value=%h ok=%b with none expected",
                                     m_tdata, m_tuser));
                end else begin
                    if (m_tdata !== results_due[0].value) begin
                        report($sformatf("value %h, expected %h",
                                         m_tdata, results_due[0].value));
                    end
                    if (m_tuser !== results_due[0].ok) begin
                        report($sformatf("ok %b, expected %b", m_tuser, results_due[0].ok));
                    end
                    void'(results_due.pop_front());
                end
            end
        end
    end

    // Input driver: presents queued characters with a random gap before each.
    always @(negedge aclk) begin
        if (aresetn) begin
            if (char_taken) begin
                char_taken = 1'b0;
                char_busy = 1'b0;
                send_gap = quiet ? 0 : $urandom_range(0, 3);
            end
            if (!char_busy) begin
                if (send_gap != 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (chars_to_send.size() != 0) begin
                    next_char = chars_to_send.pop_front();
                    s_tdata <= next_char.ch;
                    s_tlast <= next_char.last;
                    s_tvalid <= 1'b1;
                    char_busy = 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result receiver: stalls for a random gap after each transfer.
    always @(negedge aclk) begin
        if (aresetn) begin
            if (result_taken) begin
                result_taken = 1'b0;
                recv_gap = quiet ? 0 : $urandom_range(0, 3);
            end
            if (hold_off) begin
                m_tready <= 1'b0;
            end else if (recv_gap != 0) begin
                recv_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Long receiver hold-off so that the step queue fills and stalls the input.
    initial begin
        while (n_accepted < 200) @(posedge aclk);
        hold_off = 1'b1;
        repeat (80) @(posedge aclk);
        hold_off = 1'b0;
    end

    // Overall time limit.
    initial begin
        #3_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // Stimulus, reset and end of run.
    initial begin
        int         n;
        int         bad_at;
        logic       has_prefix;
        radix_t     r;
        logic [7:0] c;
        logic [3:0] h;

        // Directed literals: every radix, short and failing forms, wrap, odd codes.
        push_text("0");
        push_text("0x");
        push_text("0xfa");
        push_text("0b101");
        push_text("0o17");
        push_text("0d9");
        push_text("0XF");
        push_text("70000");
        push_char(8'h31, 1'b0);
        push_char(8'h00, 1'b1);
        push_char(8'hff, 1'b1);

        // Random literals: mostly well formed, some with a broken digit, some noise.
        while (chars_to_send.size() < 630) begin
            if ($urandom_range(0, 9) == 0) begin
                n = $urandom_range(1, 4);
                for (int i = 0; i < n; i++) begin
                    push_char(8'($urandom_range(0, 255)), i == n - 1);
                end
            end else begin
                r = radix_t'($urandom_range(0, 3));
                has_prefix = $urandom_range(0, 4) != 0;
                n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 6);
                bad_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, n - 1) : -1;
                if (has_prefix) begin
                    push_char(CH_ZERO, 1'b0);
                    unique case (r)
                        RADIX_BIN: push_char(CH_B, 1'b0);
                        RADIX_OCT: push_char(CH_O, 1'b0);
                        RADIX_DEC: push_char(CH_D, 1'b0);
                        default:   push_char(CH_X, 1'b0);
                    endcase
                end else begin
                    r = RADIX_DEC;
                end
                for (int i = 0; i < n; i++) begin
                    unique case (r)
                        RADIX_BIN: c = 8'(CH_ZERO + $urandom_range(0, 1));
                        RADIX_OCT: c = 8'(CH_ZERO + $urandom_range(0, 7));
                        RADIX_DEC: c = 8'(CH_ZERO + $urandom_range(0, 9));
                        default: begin
                            h = 4'($urandom_range(0, 15));
                            c = (h < 10) ? 8'(CH_ZERO + h) : 8'(CH_A + h - 8'd10);
                        end
                    endcase
                    if (i == bad_at) c = 8'($urandom_range(0, 255));
                    push_char(c, i == n - 1);
                end
            end
        end

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Wait for every character to be taken and every result to arrive.
        while (chars_to_send.size() != 0 || char_busy) @(posedge aclk);
        while (results_due.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        if (results_due.size() != 0) begin
            report($sformatf("%0d results never arrived", results_due.size()));
        end
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

FILE: radix_prefixed_literal_parser_top.f
+incdir+src
src/rplp_pkg.sv
src/rplp_front.sv
src/rplp_queue.sv
src/rplp_back.sv
src/radix_prefixed_literal_parser_top.sv
dv/tb.sv
